[rtl/tpb_pkg.sv]
// Shared types and constants for the turtle plotter bitmap block.
// No dependencies; used by every module in rtl/ but tpb_ram.
`default_nettype none

package tpb_pkg;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int DIST_W = 6;
    localparam int ROW_W  = 6;
    localparam int BITS_W = 64;

    // Defaults
    localparam int GRID_DEF  = 64;
    localparam int START_DEF = 25;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PEN_UP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FORWARD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRINT    = 3'd5;

    // Heading codes
    localparam logic [1:0] HEAD_N = 2'd0;
    localparam logic [1:0] HEAD_E = 2'd1;
    localparam logic [1:0] HEAD_S = 2'd2;
    localparam logic [1:0] HEAD_W = 2'd3;

    // Register indexes
    localparam logic REG_START_ROW = 1'b0;
    localparam logic REG_START_COL = 1'b1;

    // Row walk request: mark rows lo..hi with mask, or print them
    typedef struct packed {
        logic              go;
        logic              print;
        logic [ROW_W-1:0]  lo;
        logic [ROW_W-1:0]  hi;
        logic [BITS_W-1:0] mask;
    } t_walk;

endpackage

`default_nettype wire

[rtl/turtle_plotter_bitmap.sv]
// Turtle plotter top level: turtle state, configuration port, command intake.
// Depends on tpb_pkg, tpb_plan, tpb_walk (which holds tpb_ram).
`default_nettype none

// The turtle keeps its GRID x GRID bitmap in a RAM with one row per word; a
// single row walker does all bitmap work, one row per cycle while the print
// sink does not stall. Pen up, turns, unused codes and forward with the pen
// up finish in the accept cycle, so the next item can follow on the next edge.
// Pen down and a horizontal forward with the pen down touch one row: o_stall
// stays high while the walker reads that row and writes it back. A vertical
// forward with the pen down holds o_stall while the walker marks each row it
// covers. Print holds o_stall until every row has been read out and the last
// row item has left the output register; a sink stall holds the walk. The row
// rate is set by the single read and single write port of the bitmap RAM.
// Per-row valid flops stand for the reset clear, so the block takes items
// right after reset. Configuration writes move the turtle to the new start
// coordinate on that axis.

module turtle_plotter_bitmap #(
    parameter int GRID = tpb_pkg::GRID_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command items
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [tpb_pkg::CMD_W-1:0]   i_command,
    input  wire logic [tpb_pkg::DIST_W-1:0]  i_distance,
    // print row items
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [tpb_pkg::BITS_W-1:0]  o_row_bits,
    output logic      [tpb_pkg::ROW_W-1:0]   o_row_number,
    output logic                             o_last_row,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    localparam int PW = $clog2(GRID);
    localparam logic [PW-1:0] START_POS =
        (tpb_pkg::START_DEF > GRID - 1) ? PW'(GRID - 1) : PW'(tpb_pkg::START_DEF);

    logic [tpb_pkg::ROW_W-1:0] r_start_row, r_start_col;
    logic [PW-1:0]             r_pos_row, r_pos_col;
    logic [1:0]                r_heading;
    logic                      r_pen;

    logic [PW-1:0]             p_pos_row, p_pos_col;
    logic [1:0]                p_heading;
    logic                      p_pen;
    tpb_pkg::t_walk            p_walk, w_start;
    logic                      w_busy, accept, cfg_wr;
    logic [tpb_pkg::ROW_W-1:0] cfg_val;
    logic [PW-1:0]             cfg_pos;

    tpb_plan #(
        .GRID (GRID)
    ) u_plan (
        .i_command  (i_command),
        .i_distance (i_distance),
        .i_pos_row  (r_pos_row),
        .i_pos_col  (r_pos_col),
        .i_heading  (r_heading),
        .i_pen      (r_pen),
        .o_pos_row  (p_pos_row),
        .o_pos_col  (p_pos_col),
        .o_heading  (p_heading),
        .o_pen      (p_pen),
        .o_walk     (p_walk)
    );

    // Start the walker only on an accepted item
    always_comb begin
        accept     = i_valid && !o_stall;
        w_start    = p_walk;
        w_start.go = p_walk.go && accept;
    end

    tpb_walk #(
        .GRID (GRID)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .o_busy       (w_busy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_bits   (o_row_bits),
        .o_row_number (o_row_number),
        .o_last_row   (o_last_row)
    );

    // Configuration decode; the new position is the start value saturated to the grid
    always_comb begin
        cfg_wr  = psel && penable && pwrite;
        cfg_val = pwdata[tpb_pkg::ROW_W-1:0];
        cfg_pos = (int'(cfg_val) > GRID - 1) ? PW'(GRID - 1) : PW'(cfg_val);
    end

    // Turtle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= tpb_pkg::ROW_W'(tpb_pkg::START_DEF);
            r_start_col <= tpb_pkg::ROW_W'(tpb_pkg::START_DEF);
            r_pos_row   <= START_POS;
            r_pos_col   <= START_POS;
            r_heading   <= tpb_pkg::HEAD_N;
            r_pen       <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == tpb_pkg::REG_START_ROW) begin
                r_start_row <= cfg_val;
                r_pos_row   <= cfg_pos;
            end else begin
                r_start_col <= cfg_val;
                r_pos_col   <= cfg_pos;
            end
        end else if (accept) begin
            r_pos_row <= p_pos_row;
            r_pos_col <= p_pos_col;
            r_heading <= p_heading;
            r_pen     <= p_pen;
        end
    end

    assign o_stall = w_busy;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == tpb_pkg::REG_START_COL) ? 32'(r_start_col)
                                                          : 32'(r_start_row);

`ifndef SYNTH
    // A row on the output means the walker is still busy
    a_out_holds_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("row item shown while block accepts commands");

    // An accepted print starts the walker
    a_print_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == tpb_pkg::CMD_PRINT) |=> o_stall)
        else $error("print accepted but walker idle");

    // Last flag only on the final row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_row) |-> (o_row_number == tpb_pkg::ROW_W'(GRID - 1)))
        else $error("last flag on wrong row");

    // Turtle never leaves the grid
    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_pos_row) <= GRID - 1) && (int'(r_pos_col) <= GRID - 1))
        else $error("turtle position outside grid");
`endif

endmodule

`default_nettype wire

[rtl/tpb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tpb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/tpb_plan.sv]
// Command decode: next turtle position, heading, pen and the row walk to run.
// Depends on tpb_pkg.
`default_nettype none

module tpb_plan #(
    parameter int GRID = tpb_pkg::GRID_DEF
) (
    input  wire logic [tpb_pkg::CMD_W-1:0]  i_command,
    input  wire logic [tpb_pkg::DIST_W-1:0] i_distance,
    input  wire logic [$clog2(GRID)-1:0]    i_pos_row,
    input  wire logic [$clog2(GRID)-1:0]    i_pos_col,
    input  wire logic [1:0]                 i_heading,
    input  wire logic                       i_pen,
    output logic      [$clog2(GRID)-1:0]    o_pos_row,
    output logic      [$clog2(GRID)-1:0]    o_pos_col,
    output logic      [1:0]                 o_heading,
    output logic                            o_pen,
    output tpb_pkg::t_walk                  o_walk
);

    localparam int PW = $clog2(GRID);
    localparam int SW = tpb_pkg::DIST_W + 1;

    logic [SW-1:0]   r0x, c0x, dx, lim, sum_r, sum_c;
    logic [PW-1:0]   r1, c1, rlo, rhi, clo, chi;
    logic [GRID-1:0] ones, hmask;

    // Target position, saturated at the grid edges
    always_comb begin
        r0x   = SW'(i_pos_row);
        c0x   = SW'(i_pos_col);
        dx    = SW'(i_distance);
        lim   = SW'(GRID - 1);
        sum_r = r0x + dx;
        sum_c = c0x + dx;
        r1    = i_pos_row;
        c1    = i_pos_col;
        case (i_heading)
            tpb_pkg::HEAD_N: r1 = (dx > r0x) ? '0 : PW'(r0x - dx);
            tpb_pkg::HEAD_S: r1 = (sum_r > lim) ? PW'(GRID - 1) : PW'(sum_r);
            tpb_pkg::HEAD_E: c1 = (sum_c > lim) ? PW'(GRID - 1) : PW'(sum_c);
            default:         c1 = (dx > c0x) ? '0 : PW'(c0x - dx);
        endcase
        rlo   = (i_pos_row < r1) ? i_pos_row : r1;
        rhi   = (i_pos_row < r1) ? r1 : i_pos_row;
        clo   = (i_pos_col < c1) ? i_pos_col : c1;
        chi   = (i_pos_col < c1) ? c1 : i_pos_col;
        ones  = '1;
        hmask = (ones << clo) & (ones >> (PW'(GRID - 1) - chi));
    end

    // Command decode
    always_comb begin
        o_pos_row = i_pos_row;
        o_pos_col = i_pos_col;
        o_heading = i_heading;
        o_pen     = i_pen;
        o_walk    = '0;
        case (i_command)
            tpb_pkg::CMD_PEN_UP: begin
                o_pen = 1'b0;
            end
            tpb_pkg::CMD_PEN_DOWN: begin
                o_pen       = 1'b1;
                o_walk.go   = 1'b1;
                o_walk.lo   = tpb_pkg::ROW_W'(i_pos_row);
                o_walk.hi   = tpb_pkg::ROW_W'(i_pos_row);
                o_walk.mask = tpb_pkg::BITS_W'(1) << i_pos_col;
            end
            tpb_pkg::CMD_RIGHT: begin
                o_heading = i_heading + 2'd1;
            end
            tpb_pkg::CMD_LEFT: begin
                o_heading = i_heading - 2'd1;
            end
            tpb_pkg::CMD_FORWARD: begin
                o_pos_row = r1;
                o_pos_col = c1;
                o_walk.go = i_pen;
                o_walk.lo = tpb_pkg::ROW_W'(rlo);
                o_walk.hi = tpb_pkg::ROW_W'(rhi);
                // vertical moves set one column in many rows, horizontal a run in one row
                if (i_heading inside {tpb_pkg::HEAD_N, tpb_pkg::HEAD_S}) begin
                    o_walk.mask = tpb_pkg::BITS_W'(1) << i_pos_col;
                end else begin
                    o_walk.mask = tpb_pkg::BITS_W'(hmask);
                end
            end
            tpb_pkg::CMD_PRINT: begin
                o_walk.go    = 1'b1;
                o_walk.print = 1'b1;
                o_walk.lo    = '0;
                o_walk.hi    = tpb_pkg::ROW_W'(GRID - 1);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/tpb_walk.sv]
// Row walker: one bitmap row per cycle while the print sink does not stall,
// read-modify-write for marking or read-out through an output register for
// print. Holds the bitmap RAM. Depends on tpb_pkg and tpb_ram.
`default_nettype none

module tpb_walk #(
    parameter int GRID = tpb_pkg::GRID_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tpb_pkg::t_walk              i_start,
    output logic                             o_busy,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [tpb_pkg::BITS_W-1:0]  o_row_bits,
    output logic      [tpb_pkg::ROW_W-1:0]   o_row_number,
    output logic                             o_last_row
);

    localparam int PW = $clog2(GRID);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} t_state;

    t_state          r_state, n_state;
    logic            r_print, n_print;
    logic [PW-1:0]   r_ptr, n_ptr;
    logic [PW-1:0]   r_hi, n_hi;
    logic [GRID-1:0] r_mask, n_mask;
    logic            r_pend, n_pend;
    logic [PW-1:0]   r_rd_addr, n_rd_addr;
    logic [GRID-1:0] r_vld;
    logic            r_o_valid, n_o_valid;
    logic [GRID-1:0] r_o_bits, n_o_bits;
    logic [PW-1:0]   r_o_row, n_o_row;
    logic            r_o_last, n_o_last;

    logic            out_free, consume, issue, we;
    logic [GRID-1:0] ram_q, rd_data, wdata;

    tpb_ram #(
        .WIDTH (GRID),
        .DEPTH (GRID)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_rd_addr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_ptr),
        .o_rdata (ram_q)
    );

    // Row data; rows never written read as cleared
    always_comb begin
        rd_data  = r_vld[r_rd_addr] ? ram_q : '0;
        wdata    = rd_data | r_mask;
        out_free = !r_o_valid || !i_stall;
        consume  = r_pend && (!r_print || out_free);
        we       = consume && !r_print;
        issue    = (r_state == S_RUN) && (!r_pend || consume);
    end

    // Sequencer and output register
    always_comb begin
        n_state   = r_state;
        n_print   = r_print;
        n_ptr     = r_ptr;
        n_hi      = r_hi;
        n_mask    = r_mask;
        n_pend    = issue ? 1'b1 : (consume ? 1'b0 : r_pend);
        n_rd_addr = issue ? r_ptr : r_rd_addr;
        n_o_valid = r_o_valid;
        n_o_bits  = r_o_bits;
        n_o_row   = r_o_row;
        n_o_last  = r_o_last;

        if (consume && r_print) begin
            n_o_valid = 1'b1;
            n_o_bits  = rd_data;
            n_o_row   = r_rd_addr;
            n_o_last  = (r_rd_addr == PW'(GRID - 1));
        end else if (out_free) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_start.go) begin
                    n_state = S_RUN;
                    n_print = i_start.print;
                    n_ptr   = i_start.lo[PW-1:0];
                    n_hi    = i_start.hi[PW-1:0];
                    n_mask  = i_start.mask[GRID-1:0];
                end
            end
            S_RUN: begin
                if (issue) begin
                    n_ptr = r_ptr + PW'(1);
                    if (r_ptr == r_hi) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!n_pend && !n_o_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            if (we) begin
                r_vld[r_rd_addr] <= 1'b1;
            end
        end
        r_print   <= n_print;
        r_ptr     <= n_ptr;
        r_hi      <= n_hi;
        r_mask    <= n_mask;
        r_rd_addr <= n_rd_addr;
        r_o_bits  <= n_o_bits;
        r_o_row   <= n_o_row;
        r_o_last  <= n_o_last;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_row_bits   = tpb_pkg::BITS_W'(r_o_bits);
    assign o_row_number = tpb_pkg::ROW_W'(r_o_row);
    assign o_last_row   = r_o_last;

endmodule

`default_nettype wire

[test/tb_turtle_plotter_bitmap.sv]
// Self-checking testbench for turtle_plotter_bitmap: directed command script, then random
// command streams under several start settings, with random command gaps and print-side stalls.
// Depends on tpb_pkg and the RTL under rtl/.

module tb_turtle_plotter_bitmap;

    localparam int GRID          = 64;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 50;
    localparam int N_PHASES      = 6;
    localparam int N_SCRIPT      = 25;

    // Codes the block must ignore
    localparam logic [tpb_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [tpb_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [tpb_pkg::BITS_W-1:0] ROW_BLANK = 64'h0;
    localparam logic [tpb_pkg::BITS_W-1:0] ROW_FULL  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [tpb_pkg::BITS_W-1:0] bits;
        logic [tpb_pkg::ROW_W-1:0]  num;
        logic                       last;
    } t_print_row;

    // One command item; a print may carry one row whose value is typed in
    typedef struct packed {
        logic [tpb_pkg::CMD_W-1:0]  cmd;
        logic [tpb_pkg::DIST_W-1:0] steps;
        logic                       pinned;
        logic [tpb_pkg::ROW_W-1:0]  pin_row;
        logic [tpb_pkg::BITS_W-1:0] pin_bits;
    } t_plot_step;

    // Directed script, starting from the reset position (25,25) facing north
    localparam t_plot_step SCRIPT [N_SCRIPT] = '{
        '{tpb_pkg::CMD_PRINT,    6'd0,  1'b1, 6'd25, ROW_BLANK},  // blank after reset
        '{tpb_pkg::CMD_PEN_DOWN, 6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_PRINT,    6'd0,  1'b1, 6'd25, 64'h0000_0000_0200_0000},
        '{tpb_pkg::CMD_FORWARD,  6'd63, 1'b0, 6'd0,  ROW_BLANK},  // north, hits row 0
        '{tpb_pkg::CMD_RIGHT,    6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_FORWARD,  6'd63, 1'b0, 6'd0,  ROW_BLANK},  // east, hits col 63
        '{tpb_pkg::CMD_PRINT,    6'd0,  1'b1, 6'd0,  64'hFFFF_FFFF_FE00_0000},
        '{tpb_pkg::CMD_RIGHT,    6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_FORWARD,  6'd0,  1'b0, 6'd0,  ROW_BLANK},  // zero step, pen down
        '{tpb_pkg::CMD_PEN_UP,   6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_FORWARD,  6'd40, 1'b0, 6'd0,  ROW_BLANK},  // south, no marks
        '{CMD_SPARE_6,           6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{CMD_SPARE_7,           6'd63, 1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_LEFT,     6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_FORWARD,  6'd42, 1'b0, 6'd0,  ROW_BLANK},  // already at east edge
        '{tpb_pkg::CMD_PEN_DOWN, 6'd21, 1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_LEFT,     6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_LEFT,     6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_FORWARD,  6'd63, 1'b0, 6'd0,  ROW_BLANK},  // west across the row
        '{tpb_pkg::CMD_LEFT,     6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_FORWARD,  6'd63, 1'b0, 6'd0,  ROW_BLANK},  // south to row 63
        '{tpb_pkg::CMD_PRINT,    6'd0,  1'b1, 6'd40, ROW_FULL},
        '{tpb_pkg::CMD_RIGHT,    6'd0,  1'b0, 6'd0,  ROW_BLANK},
        '{tpb_pkg::CMD_FORWARD,  6'd21, 1'b0, 6'd0,  ROW_BLANK},  // west at col 0
        '{tpb_pkg::CMD_PRINT,    6'd0,  1'b1, 6'd63, 64'h0000_0000_0000_0001}
    };

    // DUT ports
    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_valid    = 1'b0;
    logic [tpb_pkg::CMD_W-1:0]   i_command  = '0;
    logic [tpb_pkg::DIST_W-1:0]  i_distance = '0;
    logic                        i_stall    = 1'b0;
    logic                        psel       = 1'b0;
    logic                        penable    = 1'b0;
    logic                        pwrite     = 1'b0;
    logic [2:0]                  paddr      = '0;
    logic [31:0]                 pwdata     = '0;
    logic                        o_stall;
    logic                        o_valid;
    logic [tpb_pkg::BITS_W-1:0]  o_row_bits;
    logic [tpb_pkg::ROW_W-1:0]   o_row_number;
    logic                        o_last_row;
    logic [31:0]                 prdata;
    logic                        pready;

    // Plotter model state
    logic [tpb_pkg::BITS_W-1:0]  plot_map [GRID];
    int                          turtle_row;
    int                          turtle_col;
    logic [1:0]                  turtle_head;
    bit                          pen_is_down;
    t_print_row                  pending_rows [$];

    int                          n_fail     = 0;
    bit                          no_idle    = 1'b0;
    int                          stall_left = 0;
    int                          stall_roll;

    turtle_plotter_bitmap #(.GRID(GRID)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_distance   (i_distance),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_bits   (o_row_bits),
        .o_row_number (o_row_number),
        .o_last_row   (o_last_row),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clamp_grid(input int v);
        return (v > GRID - 1) ? GRID - 1 : v;
    endfunction

    function automatic void mark_cell(input int r, input int c);
        if (r < GRID && c < GRID) plot_map[r][c] = 1'b1;
    endfunction

    // Update the plotter model with one accepted command; queue print rows
    task automatic plot_command(input t_plot_step step);
        int d, r1, c1, lo, hi, i;
        t_print_row pr;
        d = int'(step.steps);
        case (step.cmd)
            tpb_pkg::CMD_PEN_UP: pen_is_down = 1'b0;
            tpb_pkg::CMD_PEN_DOWN: begin
                pen_is_down = 1'b1;
                mark_cell(turtle_row, turtle_col);
            end
            tpb_pkg::CMD_RIGHT: turtle_head = turtle_head + 2'd1;
            tpb_pkg::CMD_LEFT:  turtle_head = turtle_head - 2'd1;
            tpb_pkg::CMD_FORWARD: begin
                r1 = turtle_row;
                c1 = turtle_col;
                case (turtle_head)
                    tpb_pkg::HEAD_N: r1 = (d > turtle_row) ? 0 : turtle_row - d;
                    tpb_pkg::HEAD_S: r1 = clamp_grid(turtle_row + d);
                    tpb_pkg::HEAD_E: c1 = clamp_grid(turtle_col + d);
                    default:         c1 = (d > turtle_col) ? 0 : turtle_col - d;
                endcase
                if (pen_is_down) begin
                    lo = (r1 < turtle_row) ? r1 : turtle_row;
                    hi = (r1 < turtle_row) ? turtle_row : r1;
                    for (i = lo; i <= hi; i++) mark_cell(i, turtle_col);
                    lo = (c1 < turtle_col) ? c1 : turtle_col;
                    hi = (c1 < turtle_col) ? turtle_col : c1;
                    for (i = lo; i <= hi; i++) mark_cell(turtle_row, i);
                end
                turtle_row = r1;
                turtle_col = c1;
            end
            tpb_pkg::CMD_PRINT: begin
                for (i = 0; i < GRID; i++) begin
                    pr.bits = (step.pinned && i == step.pin_row) ? step.pin_bits
                                                                 : plot_map[i];
                    pr.num  = i[tpb_pkg::ROW_W-1:0];
                    pr.last = (i == GRID - 1);
                    pending_rows.push_back(pr);
                end
            end
            default: ;
        endcase
    endtask

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Present one command item and hold it until accepted
    task automatic issue_cmd(input t_plot_step step);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= step.cmd;
        i_distance <= step.steps;
        do @(posedge i_clk); while (o_stall);
        plot_command(step);
    endtask

    // Start register write and read-back; the turtle jumps to the new start on that axis
    task automatic write_start(input logic reg_idx, input int value);
        logic [31:0] word;
        logic [31:0] want_rd;
        word      = $urandom();
        word[5:0] = value[5:0];
        want_rd   = 32'(value[5:0]);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // read back the same register
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want_rd) begin
            $error("prdata: expected %h, got %h", want_rd, prdata);
            n_fail++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == tpb_pkg::REG_START_ROW) turtle_row = clamp_grid(int'(value[5:0]));
        else                                   turtle_col = clamp_grid(int'(value[5:0]));
    endtask

    // Drop valid, drain all print rows, then let any bitmap walk finish
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_rows.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_items);
        t_plot_step step;
        int roll, k;
        for (k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (roll < 40)      step.cmd = tpb_pkg::CMD_FORWARD;
            else if (roll < 52) step.cmd = tpb_pkg::CMD_RIGHT;
            else if (roll < 64) step.cmd = tpb_pkg::CMD_LEFT;
            else if (roll < 76) step.cmd = tpb_pkg::CMD_PEN_UP;
            else if (roll < 88) step.cmd = tpb_pkg::CMD_PEN_DOWN;
            else if (roll < 96) step.cmd = tpb_pkg::CMD_PRINT;
            else                step.cmd = roll[0] ? CMD_SPARE_6 : CMD_SPARE_7;
            // short moves keep the picture varied; full range for the rest
            if ($urandom_range(99) < 70) step.steps = tpb_pkg::DIST_W'($urandom_range(12));
            else                         step.steps = tpb_pkg::DIST_W'($urandom_range(63));
            step.pinned   = 1'b0;
            step.pin_row  = '0;
            step.pin_bits = '0;
            issue_cmd(step);
        end
    endtask

    // Print side stalls: mostly free, single-cycle stalls, occasional bursts
    always @(negedge i_clk) begin
        if (no_idle) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_roll = $urandom_range(99);
            if (stall_roll < 70) begin
                i_stall <= 1'b0;
            end else if (stall_roll < 95) begin
                i_stall <= 1'b1;
            end else begin
                stall_left = $urandom_range(25, 10);
                i_stall <= 1'b1;
            end
        end
    end

    // Row item checker
    always @(posedge i_clk) begin
        t_print_row want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected row item, row_number %0d", o_row_number);
                n_fail++;
            end else begin
                want = pending_rows.pop_front();
                if (o_row_bits !== want.bits) begin
                    $error("row_bits: expected %h, got %h", want.bits, o_row_bits);
                    n_fail++;
                end
                if (o_row_number !== want.num) begin
                    $error("row_number: expected %0d, got %0d", want.num, o_row_number);
                    n_fail++;
                end
                if (o_last_row !== want.last) begin
                    $error("last_row: expected %b, got %b", want.last, o_last_row);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        int start_rows [N_PHASES];
        int start_cols [N_PHASES];
        int k, p;

        for (k = 0; k < GRID; k++) plot_map[k] = '0;
        turtle_row  = tpb_pkg::START_DEF;
        turtle_col  = tpb_pkg::START_DEF;
        turtle_head = tpb_pkg::HEAD_N;
        pen_is_down = 1'b0;

        // corners first, then two random starts
        start_rows = '{0, 63, 0, 63, 0, 0};
        start_cols = '{0, 63, 63, 0, 0, 0};
        for (k = 4; k < N_PHASES; k++) begin
            start_rows[k] = $urandom_range(63);
            start_cols[k] = $urandom_range(63);
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_SCRIPT; k++) issue_cmd(SCRIPT[k]);
        settle();

        for (p = 0; p < N_PHASES; p++) begin
            write_start(tpb_pkg::REG_START_ROW, start_rows[p]);
            write_start(tpb_pkg::REG_START_COL, start_cols[p]);
            no_idle = (p == 2);
            run_random(PHASE_ITEMS);
            settle();
        end

        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
